>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file etsu_checker.sv
// depends on nothing; clock and reset are passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/etsu_pkg.sv
// types, codes and character helpers for the expression token scanner
// used by every module of the block; depends on nothing
package etsu_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_NUM   = 2'd1,
		MODE_IDENT = 2'd2,
		MODE_COLON = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		KIND_CONST   = 4'd0,
		KIND_IDENT   = 4'd1,
		KIND_ADD     = 4'd2,
		KIND_MUL     = 4'd3,
		KIND_SEMI    = 4'd4,
		KIND_LPAREN  = 4'd5,
		KIND_RPAREN  = 4'd6,
		KIND_ASSIGN  = 4'd7,
		KIND_INVALID = 4'd8,
		KIND_END     = 4'd9
	} kind_t;

	// one tagged character
	typedef struct packed {
		logic [7:0] ch;
		kind_t      kind;
		logic       first;
		logic       last;
	} res_t;

	// everything one input word produces; r1 only counts when two is set
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} pair_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
	endfunction

	// class of a character that forms a token by itself
	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_PLUS, CH_MINUS: k = KIND_ADD;
			CH_STAR, CH_SLASH: k = KIND_MUL;
			CH_SEMI:           k = KIND_SEMI;
			CH_LPAR:           k = KIND_LPAREN;
			CH_RPAR:           k = KIND_RPAREN;
			default:           k = KIND_INVALID;
		endcase
		return k;
	endfunction

endpackage

>>> hw/rtl/expression_token_scanner_unit.sv
// Path: an accepted word's results go into the pair queue, then the output register;
// digits, letters and colons wait for the next word to settle their token.
// Throughput: one character per cycle in unless full, one result per cycle out while
// popped; the four-entry pair queue absorbs the burst of a two-result word.
// Reset: arst_n clears the scan mode, held character, queue and output valid flag.
// Holds the top level; depends on etsu_pkg, etsu_front, etsu_queue, etsu_back.
module expression_token_scanner_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic [3:0] token_kind,
	output logic       token_first,
	output logic       token_last,
	output logic       last_of_run
);
	import etsu_pkg::*;

	logic  q_push, q_pop, q_full, q_empty;
	pair_t q_wdata, q_rdata;

	assign full = q_full;

	etsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	etsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	etsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.token_kind  (token_kind),
		.token_first (token_first),
		.token_last  (token_last),
		.last_of_run (last_of_run)
	);

endmodule

>>> hw/rtl/etsu_front.sv
// front end: accepts characters, tracks the scan mode and the held character,
// and builds the one or two tagged results of each word; uses etsu_pkg
module etsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [7:0]     char_code,
	input  logic           end_of_text,
	input  logic           q_full,
	output logic           q_push,
	output etsu_pkg::pair_t q_wdata
);
	import etsu_pkg::*;

	mode_t      mode_q, mode_d;
	logic [7:0] held_q, held_d;
	logic       first_q, first_d;

	logic  accept;
	logic  any;
	logic  sc_space, sc_hold, cont;
	mode_t sc_mode;
	res_t  sc_res, flush_res, end_res, r0, r1;
	logic  two;

	assign accept = push && !q_full;

	// classify the incoming character
	always_comb begin
		sc_space = is_space(char_code);
		sc_hold  = is_digit(char_code) || is_letter(char_code) || (char_code == CH_COLON);
		if (is_digit(char_code)) begin
			sc_mode = MODE_NUM;
		end else if (is_letter(char_code)) begin
			sc_mode = MODE_IDENT;
		end else begin
			sc_mode = MODE_COLON;
		end
		sc_res = '{ch: char_code, kind: single_kind(char_code), first: 1'b1, last: 1'b1};
		if (mode_q == MODE_NUM) begin
			cont = is_digit(char_code);
		end else begin
			cont = is_letter(char_code) || is_digit(char_code) || (char_code == CH_UNDER);
		end
	end

	// the held character closing its token
	always_comb begin
		flush_res.ch    = held_q;
		flush_res.last  = 1'b1;
		flush_res.first = (mode_q == MODE_COLON) ? 1'b1 : first_q;
		case (mode_q)
			MODE_NUM:   flush_res.kind = KIND_CONST;
			MODE_IDENT: flush_res.kind = KIND_IDENT;
			default:    flush_res.kind = KIND_INVALID;
		endcase
		end_res = '{ch: 8'd0, kind: KIND_END, first: 1'b1, last: 1'b1};
	end

	// next state
	always_comb begin
		mode_d  = mode_q;
		held_d  = held_q;
		first_d = first_q;
		if (end_of_text) begin
			mode_d  = MODE_IDLE;
			held_d  = 8'd0;
			first_d = 1'b0;
		end else if ((mode_q == MODE_NUM || mode_q == MODE_IDENT) && cont) begin
			held_d  = char_code;
			first_d = 1'b0;
		end else if (mode_q == MODE_COLON && char_code == CH_EQ) begin
			mode_d  = MODE_IDLE;
			held_d  = 8'd0;
			first_d = 1'b0;
		end else if (sc_hold) begin
			mode_d  = sc_mode;
			held_d  = char_code;
			first_d = 1'b1;
		end else begin
			mode_d  = MODE_IDLE;
			held_d  = 8'd0;
			first_d = 1'b0;
		end
	end

	// results of this word
	always_comb begin
		any = 1'b0;
		two = 1'b0;
		r0  = flush_res;
		r1  = sc_res;
		if (end_of_text) begin
			any = 1'b1;
			if (mode_q != MODE_IDLE) begin
				r1  = end_res;
				two = 1'b1;
			end else begin
				r0 = end_res;
			end
		end else begin
			case (mode_q)
				MODE_NUM, MODE_IDENT: begin
					any = 1'b1;
					if (cont) begin
						r0.last = 1'b0;
					end else if (!sc_space && !sc_hold) begin
						two = 1'b1;
					end
				end
				MODE_COLON: begin
					any = 1'b1;
					if (char_code == CH_EQ) begin
						r0  = '{ch: CH_COLON, kind: KIND_ASSIGN, first: 1'b1, last: 1'b0};
						r1  = '{ch: CH_EQ, kind: KIND_ASSIGN, first: 1'b0, last: 1'b1};
						two = 1'b1;
					end else if (!sc_space && !sc_hold) begin
						two = 1'b1;
					end
				end
				default: begin
					if (!sc_space && !sc_hold) begin
						any = 1'b1;
						r0  = sc_res;
					end
				end
			endcase
		end
	end

	assign q_push  = accept && any;
	assign q_wdata = '{two: two, r0: r0, r1: r1};

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			held_q  <= 8'd0;
			first_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			held_q  <= held_d;
			first_q <= first_d;
		end
	end

endmodule

>>> hw/rtl/etsu_queue.sv
// short word queue between front and back end
// holds result pairs in flip-flops; uses etsu_pkg
module etsu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  etsu_pkg::pair_t wdata,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output etsu_pkg::pair_t rdata
);
	import etsu_pkg::*;

	pair_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/etsu_back.sv
// back end: splits queued pairs into single results into an output register
// uses etsu_pkg
module etsu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  etsu_pkg::pair_t q_rdata,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      out_char,
	output logic [3:0]      token_kind,
	output logic            token_first,
	output logic            token_last,
	output logic            last_of_run
);
	import etsu_pkg::*;

	res_t out_q;
	logic run_last_q;
	logic valid_q;
	logic phase_q;
	logic load;
	res_t pick;

	// refill the output register when it is empty or being taken
	assign load  = !q_empty && (!valid_q || pop);
	assign pick  = phase_q ? q_rdata.r1 : q_rdata.r0;
	assign q_pop = load && (!q_rdata.two || phase_q);

	always_ff @(posedge clk) begin
		if (load) begin
			out_q      <= pick;
			run_last_q <= !q_rdata.two || phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			phase_q <= q_rdata.two && !phase_q;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	assign empty       = !valid_q;
	assign out_char    = out_q.ch;
	assign token_kind  = out_q.kind;
	assign token_first = out_q.first;
	assign token_last  = out_q.last;
	assign last_of_run = run_last_q;

endmodule

>>> hw/rtl/etsu_checker.sv
// port-level checks for the expression token scanner, bound to the top level
// depends on etsu_pkg and assert_macros.svh
`include "assert_macros.svh"

module etsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] char_code,
	input logic       end_of_text,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_char,
	input logic [3:0] token_kind,
	input logic       token_first,
	input logic       token_last,
	input logic       last_of_run
);
	import etsu_pkg::*;

	logic lone_kind;
	logic in_word;

	assign in_word   = push && !full && (char_code != 8'd0 || end_of_text);
	assign lone_kind = (token_kind == KIND_ADD) || (token_kind == KIND_MUL) ||
		(token_kind == KIND_SEMI) || (token_kind == KIND_LPAREN) ||
		(token_kind == KIND_RPAREN) || (token_kind == KIND_INVALID);

	// end token is a bare one-character token closing its word
	`ASSERT_CLK(a_end_form, clk, arst_n, (!empty && token_kind == KIND_END) |-> (token_first && token_last && last_of_run && out_char == 8'd0), "malformed end token")
	// operators, brackets and invalid characters stand alone
	`ASSERT_CLK(a_lone_tok, clk, arst_n, (!empty && lone_kind) |-> (token_first && token_last), "single-character token not first and last")
	// the colon half of an assignment always has the equals sign behind it
	`ASSERT_CLK(a_assign_pair, clk, arst_n, (!empty && token_kind == KIND_ASSIGN && token_first) |-> (!token_last && !last_of_run && out_char == CH_COLON), "broken assignment pair")
	// a waiting result holds until taken, checked only while no nonzero or end word is accepted
	`ASSERT_NEXT(a_out_hold, clk, arst_n, !empty && !pop && !in_word, !empty && $stable(out_char) && $stable(token_kind), "result changed while stalled")

endmodule

bind expression_token_scanner_unit etsu_checker u_etsu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.char_code   (char_code),
	.end_of_text (end_of_text),
	.empty       (empty),
	.pop         (pop),
	.out_char    (out_char),
	.token_kind  (token_kind),
	.token_first (token_first),
	.token_last  (token_last),
	.last_of_run (last_of_run)
);

>>> tb/tb.sv
// self-checking bench for expression_token_scanner_unit: directed and random character streams
// predicts every tagged word in-bench and checks each popped word field by field
// depends on etsu_pkg and the scanner RTL
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import etsu_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_WORDS = 215;
	localparam int TAIL_CYCLES = 10;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} char_word_t;

	typedef struct {
		logic [7:0] ch;
		kind_t      kind;
		logic       first;
		logic       last;
		logic       run_end;
	} token_word_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] char_code;
	logic       end_of_text;
	logic       empty;
	logic       pop;
	logic [7:0] out_char;
	logic [3:0] token_kind;
	logic       token_first;
	logic       token_last;
	logic       last_of_run;

	char_word_t  chars_waiting[$];
	token_word_t tokens_due[$];

	// predicted scanner state
	mode_t      scan_state;
	logic [7:0] held_ch;
	logic       held_first;

	int send_idle;
	int recv_idle;
	int words_in;
	int tokens_seen;
	int errors;
	int stall_cycles;

	expression_token_scanner_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.token_kind  (token_kind),
		.token_first (token_first),
		.token_last  (token_last),
		.last_of_run (last_of_run)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// character classes
	function automatic logic numeral(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
	endfunction

	task automatic put_token(input logic [7:0] c, input kind_t k, input logic f, input logic l);
		token_word_t t;
		t.ch = c;
		t.kind = k;
		t.first = f;
		t.last = l;
		t.run_end = 1'b0;
		tokens_due.push_back(t);
	endtask

	// close the token of the held character and go idle
	task automatic flush_held();
		case (scan_state)
			MODE_NUM:   put_token(held_ch, KIND_CONST, held_first, 1'b1);
			MODE_IDENT: put_token(held_ch, KIND_IDENT, held_first, 1'b1);
			MODE_COLON: put_token(held_ch, KIND_INVALID, 1'b1, 1'b1);
			default:    ;
		endcase
		scan_state = MODE_IDLE;
		held_ch = 8'h00;
		held_first = 1'b0;
	endtask

	// scan a character with nothing held
	task automatic scan_fresh(input logic [7:0] c);
		if (blank(c)) begin
			// whitespace only ends a token
		end else if (numeral(c) || alpha(c) || c == CH_COLON) begin
			scan_state = numeral(c) ? MODE_NUM : (alpha(c) ? MODE_IDENT : MODE_COLON);
			held_ch = c;
			held_first = 1'b1;
		end else begin
			case (c)
				CH_PLUS, CH_MINUS: put_token(c, KIND_ADD, 1'b1, 1'b1);
				CH_STAR, CH_SLASH: put_token(c, KIND_MUL, 1'b1, 1'b1);
				CH_SEMI:           put_token(c, KIND_SEMI, 1'b1, 1'b1);
				CH_LPAR:           put_token(c, KIND_LPAREN, 1'b1, 1'b1);
				CH_RPAR:           put_token(c, KIND_RPAREN, 1'b1, 1'b1);
				default:           put_token(c, KIND_INVALID, 1'b1, 1'b1);
			endcase
		end
	endtask

	// expected tokens for one accepted character word
	task automatic scan_word(input logic [7:0] c, input logic eot);
		int          queued;
		logic        cont;
		token_word_t t;
		queued = tokens_due.size();
		if (eot) begin
			flush_held();
			put_token(8'h00, KIND_END, 1'b1, 1'b1);
		end else if (scan_state == MODE_NUM || scan_state == MODE_IDENT) begin
			cont = (scan_state == MODE_NUM) ? numeral(c)
				: (alpha(c) || numeral(c) || c == CH_UNDER);
			if (cont) begin
				put_token(held_ch, (scan_state == MODE_NUM) ? KIND_CONST : KIND_IDENT,
					held_first, 1'b0);
				held_ch = c;
				held_first = 1'b0;
			end else begin
				flush_held();
				scan_fresh(c);
			end
		end else if (scan_state == MODE_COLON) begin
			if (c == CH_EQ) begin
				put_token(CH_COLON, KIND_ASSIGN, 1'b1, 1'b0);
				put_token(CH_EQ, KIND_ASSIGN, 1'b0, 1'b1);
				scan_state = MODE_IDLE;
				held_ch = 8'h00;
				held_first = 1'b0;
			end else begin
				flush_held();
				scan_fresh(c);
			end
		end else begin
			scan_fresh(c);
		end
		// mark the final token of this word
		if (tokens_due.size() > queued) begin
			t = tokens_due.pop_back();
			t.run_end = 1'b1;
			tokens_due.push_back(t);
		end
	endtask

	task automatic push_word(input logic [7:0] c, input logic eot);
		char_word_t w;
		w.ch = c;
		w.eot = eot;
		chars_waiting.push_back(w);
	endtask

	function automatic logic [7:0] pick_alpha();
		return $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25))
			: 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] pick_blank();
		return ($urandom_range(0, 5) == 5) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4));
	endfunction

	// mostly well-formed expression text with some noise and broken pieces
	task automatic gen_phrase();
		int n;
		int r;
		int len;
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				push_word(pick_alpha(), 1'b0);
				len = $urandom_range(0, 5);
				repeat (len) begin
					case ($urandom_range(0, 2))
						0:       push_word(pick_alpha(), 1'b0);
						1:       push_word(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
						default: push_word(CH_UNDER, 1'b0);
					endcase
				end
			end else if (r < 45) begin
				len = $urandom_range(1, 5);
				repeat (len) push_word(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
			end else if (r < 60) begin
				case ($urandom_range(0, 3))
					0:       push_word(CH_PLUS, 1'b0);
					1:       push_word(CH_MINUS, 1'b0);
					2:       push_word(CH_STAR, 1'b0);
					default: push_word(CH_SLASH, 1'b0);
				endcase
			end else if (r < 65) begin
				push_word(CH_SEMI, 1'b0);
			end else if (r < 72) begin
				push_word(CH_LPAR, 1'b0);
			end else if (r < 79) begin
				push_word(CH_RPAR, 1'b0);
			end else if (r < 86) begin
				push_word(CH_COLON, 1'b0);
				push_word(CH_EQ, 1'b0);
			end else if (r < 90) begin
				// lone colon
				push_word(CH_COLON, 1'b0);
			end else if (r < 96) begin
				push_word(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				push_word(pick_blank(), 1'b0);
			end
			if ($urandom_range(0, 99) < 40)
				push_word(pick_blank(), 1'b0);
		end
		if ($urandom_range(0, 99) < 35)
			push_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// driver: present the oldest pending character word
	always @(negedge clk) begin
		if (arst_n && chars_waiting.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
			push <= 1'b1;
			char_code <= chars_waiting[0].ch;
			end_of_text <= chars_waiting[0].eot;
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && ($urandom_range(0, 99) >= recv_idle);
	end

	// monitor: check popped words, predict on accepted ones, watchdog
	always @(posedge clk) begin
		token_word_t e;
		logic        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (pop && !empty) begin
				moved = 1'b1;
				tokens_seen++;
				if (tokens_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word out_char %h token_kind %0d",
						$time, out_char, token_kind);
				end else begin
					e = tokens_due.pop_front();
					if (out_char !== e.ch) begin
						errors++;
						$display("%0t: out_char expected %h actual %h", $time, e.ch, out_char);
					end
					if (token_kind !== e.kind) begin
						errors++;
						$display("%0t: token_kind expected %0d actual %0d",
							$time, e.kind, token_kind);
					end
					if (token_first !== e.first) begin
						errors++;
						$display("%0t: token_first expected %b actual %b",
							$time, e.first, token_first);
					end
					if (token_last !== e.last) begin
						errors++;
						$display("%0t: token_last expected %b actual %b",
							$time, e.last, token_last);
					end
					if (last_of_run !== e.run_end) begin
						errors++;
						$display("%0t: last_of_run expected %b actual %b",
							$time, e.run_end, last_of_run);
					end
				end
			end
			if (push && !full) begin
				moved = 1'b1;
				words_in++;
				scan_word(chars_waiting[0].ch, chars_waiting[0].eot);
				void'(chars_waiting.pop_front());
			end
			if (moved || (chars_waiting.size() == 0 && tokens_due.size() == 0))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (chars_waiting.size() > 0 || tokens_due.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		char_code = 8'h00;
		end_of_text = 1'b0;
		send_idle = 28;
		recv_idle = 47;
		words_in = 0;
		tokens_seen = 0;
		errors = 0;
		stall_cycles = 0;
		scan_state = MODE_IDLE;
		held_ch = 8'h00;
		held_first = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identifier with underscore, constants, every operator, assignment,
		// lone colon, whitespace, extreme codes, colon held at end of text
		push_word("a", 1'b0);
		push_word(CH_UNDER, 1'b0);
		push_word("Z", 1'b0);
		push_word("9", 1'b0);
		push_word(8'h20, 1'b0);
		push_word("0", 1'b0);
		push_word("9", 1'b0);
		push_word(CH_PLUS, 1'b0);
		push_word(CH_MINUS, 1'b0);
		push_word(CH_STAR, 1'b0);
		push_word(CH_SLASH, 1'b0);
		push_word(CH_SEMI, 1'b0);
		push_word(CH_LPAR, 1'b0);
		push_word(CH_RPAR, 1'b0);
		push_word(CH_COLON, 1'b0);
		push_word(CH_EQ, 1'b0);
		push_word(CH_COLON, 1'b0);
		push_word("A", 1'b0);
		push_word(8'h09, 1'b0);
		push_word(8'h0D, 1'b0);
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word("z", 1'b0);
		push_word(CH_COLON, 1'b0);
		push_word(8'hFF, 1'b1);
		// sender holds off until every token is out
		wait_drained();

		// random phases with changing pacing on both sides
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 28 : ((phase == 1) ? 47 : 0);
			recv_idle = (phase == 0) ? 47 : ((phase == 1) ? 28 : 0);
			while (chars_waiting.size() < PHASE_WORDS)
				gen_phrase();
			push_word(8'($urandom_range(0, 255)), 1'b1);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("scanned %0d character words into %0d token words under three pacing mixes",
			words_in, tokens_seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
